>>> hdl/brsc_pkg.sv
// Shared constants, codes and control/status types of the byte history ring.
package brsc_pkg;

  // Ring capacity and derived widths
  localparam int DEPTH   = 32768;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FIELD_W = 16;
  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  // Counts must hold DEPTH itself and every 16-bit field value
  localparam int CNT_W   = ($clog2(DEPTH + 1) > FIELD_W) ? $clog2(DEPTH + 1) : FIELD_W;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE     = 3'd0,
    CMD_READ      = 3'd1,
    CMD_DISCARD   = 3'd2,
    CMD_COPY      = 3'd3,
    CMD_BACK_READ = 3'd4,
    CMD_CLEAR     = 3'd5
  } brsc_cmd_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    RS_OK      = 2'd0,
    RS_NONE    = 2'd1,
    RS_LIMIT   = 2'd2,
    RS_DISCARD = 2'd3
  } brsc_status_e;

  // Source of the done count in a result
  typedef enum logic [1:0] {
    DONE_ZERO  = 2'd0,
    DONE_ONE   = 2'd1,
    DONE_LEN   = 2'd2,
    DONE_COUNT = 2'd3
  } brsc_done_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic           latch;      // capture request fields
    logic           wr_byte;    // append request byte
    logic           pop;        // advance head by one
    logic           discard;    // advance head by length
    logic           rd_en;      // issue a window read
    logic           rd_back;    // read address is the back position
    logic           copy_wr;    // append the byte just read back
    logic           clear;      // empty the ring
    logic           res_load;   // load result registers
    brsc_status_e   res_status;
    logic           res_rdata;  // result carries read data
    brsc_done_sel_e res_done;
  } brsc_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] code;
    logic             full;
    logic             empty;
    logic             len_gt_used;
    logic             dist_gt_limit;
    logic             dist_zero;
    logic             copy_more;
    logic             cnt_zero;
  } brsc_flags_t;

endpackage

>>> hdl/brsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module brsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/brsc_datapath.sv
// Ring pointers, counters, window memory and result registers.
module brsc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  brsc_pkg::brsc_ctrl_t         ctrl_i,
  output brsc_pkg::brsc_flags_t        flags_o,
  input  logic [brsc_pkg::CMD_W-1:0]   command_i,
  input  logic [brsc_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic [brsc_pkg::FIELD_W-1:0] distance_i,
  input  logic [brsc_pkg::FIELD_W-1:0] length_i,
  output logic [brsc_pkg::BYTE_W-1:0]  read_data_o,
  output logic [brsc_pkg::STAT_W-1:0]  status_o,
  output logic [brsc_pkg::FIELD_W-1:0] done_count_o,
  output logic [brsc_pkg::FIELD_W-1:0] used_count_o
);
  import brsc_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  // Request fields
  logic [CMD_W-1:0]   cmd_q;
  logic [BYTE_W-1:0]  data_q;
  logic [FIELD_W-1:0] dist_q;
  logic [FIELD_W-1:0] len_q;
  logic [FIELD_W-1:0] cnt_q;

  // Ring state
  logic [ADDR_W-1:0] head_q, head_d;
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  limit_q, limit_d;

  // Result payload
  logic [BYTE_W-1:0]  rd_res_q;
  logic [STAT_W-1:0]  stat_res_q;
  logic [FIELD_W-1:0] done_res_q;

  logic [SUM_W-1:0]  disc_sum, back_sum;
  logic [ADDR_W-1:0] disc_head, back_addr, head_inc, wp_inc;
  logic              full;
  logic [BYTE_W-1:0] ram_rdata;
  logic              ram_we;
  logic [BYTE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;

  // Capture request; copy count restarts with each request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q  <= command_i;
      data_q <= data_byte_i;
      dist_q <= distance_i;
      len_q  <= length_i;
      cnt_q  <= '0;
    end else if (ctrl_i.copy_wr) begin
      cnt_q  <= cnt_q + FIELD_W'(1);
    end
  end

  // Modular pointer arithmetic: each sum stays below twice the depth
  always_comb begin
    disc_sum  = SUM_W'(head_q) + SUM_W'(len_q);
    disc_head = (disc_sum >= SUM_W'(DEPTH)) ? ADDR_W'(disc_sum - SUM_W'(DEPTH))
                                            : ADDR_W'(disc_sum);
    back_sum  = SUM_W'(wp_q) + SUM_W'(DEPTH) - SUM_W'(dist_q);
    back_addr = (back_sum >= SUM_W'(DEPTH)) ? ADDR_W'(back_sum - SUM_W'(DEPTH))
                                            : ADDR_W'(back_sum);
    head_inc  = (head_q == ADDR_W'(DEPTH - 1)) ? '0 : head_q + ADDR_W'(1);
    wp_inc    = (wp_q == ADDR_W'(DEPTH - 1)) ? '0 : wp_q + ADDR_W'(1);
  end

  assign full = (used_q == CNT_W'(DEPTH));

  // Next ring state
  always_comb begin
    head_d  = head_q;
    wp_d    = wp_q;
    used_d  = used_q;
    limit_d = limit_q;
    priority if (ctrl_i.clear) begin
      head_d  = '0;
      wp_d    = '0;
      used_d  = '0;
      limit_d = '0;
    end else if (ctrl_i.wr_byte || ctrl_i.copy_wr) begin
      wp_d   = wp_inc;
      used_d = used_q + CNT_W'(1);
      if (limit_q != CNT_W'(DEPTH)) begin
        limit_d = limit_q + CNT_W'(1);
      end
    end else if (ctrl_i.pop) begin
      head_d = head_inc;
      used_d = used_q - CNT_W'(1);
    end else if (ctrl_i.discard) begin
      head_d = disc_head;
      used_d = used_q - CNT_W'(len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      wp_q    <= '0;
      used_q  <= '0;
      limit_q <= '0;
    end else begin
      head_q  <= head_d;
      wp_q    <= wp_d;
      used_q  <= used_d;
      limit_q <= limit_d;
    end
  end

  // Window memory
  assign ram_we    = ctrl_i.wr_byte || ctrl_i.copy_wr;
  assign ram_wdata = ctrl_i.copy_wr ? ram_rdata : data_q;
  assign ram_raddr = ctrl_i.rd_back ? back_addr : head_q;

  brsc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Status to controller
  always_comb begin
    flags_o.code          = cmd_q;
    flags_o.full          = full;
    flags_o.empty         = (used_q == '0);
    flags_o.len_gt_used   = (CNT_W'(len_q) > used_q);
    flags_o.dist_gt_limit = (CNT_W'(dist_q) > limit_q);
    flags_o.dist_zero     = (dist_q == '0);
    flags_o.copy_more     = (cnt_q != len_q) && !full;
    flags_o.cnt_zero      = (cnt_q == '0);
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      rd_res_q   <= ctrl_i.res_rdata ? ram_rdata : '0;
      stat_res_q <= ctrl_i.res_status;
      unique case (ctrl_i.res_done)
        DONE_ZERO:  done_res_q <= '0;
        DONE_ONE:   done_res_q <= FIELD_W'(1);
        DONE_LEN:   done_res_q <= len_q;
        DONE_COUNT: done_res_q <= cnt_q;
        default:    done_res_q <= '0;
      endcase
    end
  end

  assign read_data_o  = rd_res_q;
  assign status_o     = stat_res_q;
  assign done_count_o = done_res_q;
  // Held count is stable from the result cycle until the next request executes
  assign used_count_o = FIELD_W'(used_q);

endmodule

>>> hdl/brsc_ctrl.sv
// Command sequencer: decodes each request and steps reads, copies and results.
module brsc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  output logic                  result_valid_o,
  input  brsc_pkg::brsc_flags_t flags_i,
  output brsc_pkg::brsc_ctrl_t  ctrl_o
);
  import brsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_COPY_RD,
    ST_COPY_WR
  } state_e;

  state_e state_q, state_d;
  logic   result_valid_q;

  // Command decode per state
  always_comb begin
    ctrl_o  = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d         = ST_IDLE;
        ctrl_o.res_load = 1'b1;
        ctrl_o.res_status = RS_NONE;
        ctrl_o.res_done   = DONE_ZERO;
        unique case (brsc_cmd_e'(flags_i.code))
          CMD_WRITE: begin
            if (!flags_i.full) begin
              ctrl_o.wr_byte    = 1'b1;
              ctrl_o.res_status = RS_OK;
              ctrl_o.res_done   = DONE_ONE;
            end
          end
          CMD_READ: begin
            if (!flags_i.empty) begin
              ctrl_o.pop      = 1'b1;
              ctrl_o.rd_en    = 1'b1;
              ctrl_o.res_load = 1'b0;
              state_d         = ST_RDWAIT;
            end
          end
          CMD_DISCARD: begin
            if (flags_i.len_gt_used) begin
              ctrl_o.res_status = RS_DISCARD;
            end else begin
              ctrl_o.discard    = 1'b1;
              ctrl_o.res_status = RS_OK;
              ctrl_o.res_done   = DONE_LEN;
            end
          end
          CMD_COPY: begin
            if (flags_i.dist_gt_limit) begin
              ctrl_o.res_status = RS_LIMIT;
            end else if (!flags_i.dist_zero) begin
              ctrl_o.res_load = 1'b0;
              state_d         = ST_COPY_RD;
            end
          end
          CMD_BACK_READ: begin
            if (flags_i.dist_gt_limit) begin
              ctrl_o.res_status = RS_LIMIT;
            end else if (!flags_i.dist_zero) begin
              ctrl_o.rd_en    = 1'b1;
              ctrl_o.rd_back  = 1'b1;
              ctrl_o.res_load = 1'b0;
              state_d         = ST_RDWAIT;
            end
          end
          CMD_CLEAR: begin
            ctrl_o.clear      = 1'b1;
            ctrl_o.res_status = RS_OK;
          end
          default: begin
            ctrl_o.res_status = RS_NONE;
          end
        endcase
      end
      // Read data is out of the memory register now
      ST_RDWAIT: begin
        ctrl_o.res_load   = 1'b1;
        ctrl_o.res_status = RS_OK;
        ctrl_o.res_rdata  = 1'b1;
        ctrl_o.res_done   = DONE_ONE;
        state_d           = ST_IDLE;
      end
      // Fetch the next byte behind the write point, or finish
      ST_COPY_RD: begin
        if (flags_i.copy_more) begin
          ctrl_o.rd_en   = 1'b1;
          ctrl_o.rd_back = 1'b1;
          state_d        = ST_COPY_WR;
        end else begin
          ctrl_o.res_load   = 1'b1;
          ctrl_o.res_status = flags_i.cnt_zero ? RS_NONE : RS_OK;
          ctrl_o.res_done   = DONE_COUNT;
          state_d           = ST_IDLE;
        end
      end
      // Append the fetched byte
      ST_COPY_WR: begin
        ctrl_o.copy_wr = 1'b1;
        state_d        = ST_COPY_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= ctrl_o.res_load;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;

endmodule

>>> hdl/byte_ring_with_seekback_copy.sv
// Top level of the byte history ring with back-distance read and copy.
//
// Requests: drive command_i, data_byte_i, distance_i and length_i and raise
// start_i; the request is taken at a rising edge where busy_o is low. busy_o
// stays high until the request is finished; start_i is ignored meanwhile.
// Results: result_valid_o is high for exactly one cycle with read_data_o,
// status_o, done_count_o and used_count_o. The receiver cannot stall and must
// take the result in that cycle; the strobe cycle is also free for a new
// request.
// Write, discard, clear, refused or failed requests finish in the execute state;
// read and back read add one registered window memory read; a copy of N bytes
// passes through the copy read and copy write states once per byte and ends
// in the copy read state, also for N = 0 (zero length or full ring).
// Each byte is a memory read followed by a write at the write point, so
// overlapping copies repeat the pattern.
// A new request can be taken in the cycle its predecessor strobes its result.
// Reset (rst_ni low, asynchronous) empties the ring and clears the back
// distance limit; window contents are not cleared and need no sweep.
module byte_ring_with_seekback_copy (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [brsc_pkg::CMD_W-1:0]   command_i,
  input  logic [brsc_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic [brsc_pkg::FIELD_W-1:0] distance_i,
  input  logic [brsc_pkg::FIELD_W-1:0] length_i,
  output logic                         result_valid_o,
  output logic [brsc_pkg::BYTE_W-1:0]  read_data_o,
  output logic [brsc_pkg::STAT_W-1:0]  status_o,
  output logic [brsc_pkg::FIELD_W-1:0] done_count_o,
  output logic [brsc_pkg::FIELD_W-1:0] used_count_o
);
  import brsc_pkg::*;

  brsc_ctrl_t  ctrl;
  brsc_flags_t flags;

  // Sequencer
  brsc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .flags_i        (flags),
    .ctrl_o         (ctrl)
  );

  // Datapath
  brsc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .flags_o      (flags),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .distance_i   (distance_i),
    .length_i     (length_i),
    .read_data_o  (read_data_o),
    .status_o     (status_o),
    .done_count_o (done_count_o),
    .used_count_o (used_count_o)
  );

`ifndef SYNTH
  // No byte is ever appended to a full ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags.full |-> !(ctrl.wr_byte || ctrl.copy_wr))
    else $error("append issued while ring is full");

  // A taken request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request taken but block not busy");

  // Results appear only once the request is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while busy");

  // A request that did nothing or failed reports no bytes done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != RS_OK)) |-> (done_count_o == '0))
    else $error("nonzero done count on failed request");
`endif

endmodule

>>> test/tb_byte_ring_with_seekback_copy.sv
// Self-checking testbench for the byte history ring: directed table, then random requests.
`timescale 1ns / 100ps

module tb_byte_ring_with_seekback_copy;
  import brsc_pkg::*;

  localparam int          RANDOM_ITEMS = 400;
  localparam int          BIG_COPY_MAX = 4;
  localparam longint      LIMIT_NS     = 64'd60_000_000;  // watchdog time limit in ns
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // One result of the ring
  typedef struct packed {
    logic [BYTE_W-1:0]  rdata;
    brsc_status_e       status;
    logic [FIELD_W-1:0] done;
    logic [FIELD_W-1:0] used;
  } ring_result_t;

  // One row of the directed table; typed rows carry their own expected result
  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [BYTE_W-1:0]  data;
    logic [FIELD_W-1:0] back_dist;
    logic [FIELD_W-1:0] len;
    bit                 typed;
    ring_result_t       res;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 start_i      = 1'b0;
  logic [CMD_W-1:0]     command_i    = '0;
  logic [BYTE_W-1:0]    data_byte_i  = '0;
  logic [FIELD_W-1:0]   distance_i   = '0;
  logic [FIELD_W-1:0]   length_i     = '0;
  logic                 busy_o;
  logic                 result_valid_o;
  logic [BYTE_W-1:0]    read_data_o;
  logic [STAT_W-1:0]    status_o;
  logic [FIELD_W-1:0]   done_count_o;
  logic [FIELD_W-1:0]   used_count_o;

  // Predicted ring state
  logic [BYTE_W-1:0]    hist_mem [DEPTH];
  logic [ADDR_W-1:0]    ring_head;
  logic [CNT_W-1:0]     ring_used;
  logic [CNT_W-1:0]     ring_limit;

  ring_result_t         pending_q [$];
  stim_row_t            dir_rows [$];
  int                   n_fail;
  int                   burst_left;
  int                   big_copies;

  byte_ring_with_seekback_copy i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .distance_i     (distance_i),
    .length_i       (length_i),
    .result_valid_o (result_valid_o),
    .read_data_o    (read_data_o),
    .status_o       (status_o),
    .done_count_o   (done_count_o),
    .used_count_o   (used_count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("tb_byte_ring_with_seekback_copy NOT OK");
    $finish;
  end

  // Append one byte at the write point; the seekback limit saturates at capacity
  function automatic void ring_push(logic [BYTE_W-1:0] b);
    int unsigned wp;
    wp = (int'(ring_head) + int'(ring_used)) % DEPTH;
    hist_mem[wp] = b;
    ring_used++;
    if (ring_limit < DEPTH) ring_limit++;
  endfunction

  // Byte at a back distance from the write point
  function automatic logic [BYTE_W-1:0] ring_back(logic [FIELD_W-1:0] back_dist);
    int unsigned wp;
    wp = (int'(ring_head) + int'(ring_used)) % DEPTH;
    return hist_mem[(wp + DEPTH - int'(back_dist)) % DEPTH];
  endfunction

  // Apply one request to the predicted ring and return its result
  function automatic ring_result_t ring_apply(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                              logic [FIELD_W-1:0] back_dist,
                                              logic [FIELD_W-1:0] len);
    ring_result_t r;
    r.rdata  = '0;
    r.status = RS_NONE;
    r.done   = '0;
    case (cmd)
      CMD_WRITE: begin
        if (ring_used < DEPTH) begin
          ring_push(data);
          r.status = RS_OK;
          r.done   = FIELD_W'(1);
        end
      end
      CMD_READ: begin
        if (ring_used != 0) begin
          r.rdata   = hist_mem[ring_head];
          ring_head = ADDR_W'((int'(ring_head) + 1) % DEPTH);
          ring_used--;
          r.status  = RS_OK;
          r.done    = FIELD_W'(1);
        end
      end
      CMD_DISCARD: begin
        if (len > ring_used) begin
          r.status = RS_DISCARD;
        end else begin
          ring_used = ring_used - len;
          ring_head = ADDR_W'((int'(ring_head) + int'(len)) % DEPTH);
          r.status  = RS_OK;
          r.done    = len;
        end
      end
      CMD_COPY: begin
        if (back_dist > ring_limit) begin
          r.status = RS_LIMIT;
        end else if (back_dist != 0) begin
          // byte by byte, so an overlapping copy repeats the pattern
          while (r.done < len && ring_used < DEPTH) begin
            ring_push(ring_back(back_dist));
            r.done++;
          end
          r.status = (r.done != 0) ? RS_OK : RS_NONE;
        end
      end
      CMD_BACK_READ: begin
        if (back_dist > ring_limit) begin
          r.status = RS_LIMIT;
        end else if (back_dist != 0) begin
          r.rdata  = ring_back(back_dist);
          r.status = RS_OK;
          r.done   = FIELD_W'(1);
        end
      end
      CMD_CLEAR: begin
        ring_head  = '0;
        ring_used  = '0;
        ring_limit = '0;
        r.status   = RS_OK;
      end
      default: ;
    endcase
    r.used = ring_used[FIELD_W-1:0];
    return r;
  endfunction

  // Back distance: mostly inside the window, some zero, just beyond, or noise
  function automatic logic [FIELD_W-1:0] pick_distance();
    int unsigned near;
    near = (ring_limit < 40) ? ring_limit : 40;
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return FIELD_W'($urandom);
      2:       return ring_limit + FIELD_W'($urandom_range(3, 1));
      3:       return FIELD_W'($urandom_range(int'(ring_limit), 0));
      default: return (near == 0) ? FIELD_W'(1) : FIELD_W'($urandom_range(near, 1));
    endcase
  endfunction

  task automatic row(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                     logic [FIELD_W-1:0] back_dist, logic [FIELD_W-1:0] len);
    stim_row_t s;
    s.cmd       = cmd;
    s.data      = data;
    s.back_dist = back_dist;
    s.len       = len;
    s.typed     = 1'b0;
    s.res       = '0;
    dir_rows.push_back(s);
  endtask

  task automatic row_exp(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                         logic [FIELD_W-1:0] back_dist, logic [FIELD_W-1:0] len,
                         logic [BYTE_W-1:0] rdata, brsc_status_e status,
                         logic [FIELD_W-1:0] done, logic [FIELD_W-1:0] used);
    stim_row_t s;
    s.cmd        = cmd;
    s.data       = data;
    s.back_dist  = back_dist;
    s.len        = len;
    s.typed      = 1'b1;
    s.res.rdata  = rdata;
    s.res.status = status;
    s.res.done   = done;
    s.res.used   = used;
    dir_rows.push_back(s);
  endtask

  // Drive one request, hold it until taken, then record what it should return
  task automatic issue_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                               logic [FIELD_W-1:0] back_dist, logic [FIELD_W-1:0] len,
                               bit typed, ring_result_t typed_res);
    ring_result_t pred;
    start_i     <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= data;
    distance_i  <= back_dist;
    length_i    <= len;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pred = ring_apply(cmd, data, back_dist, len);
    pending_q.push_back(typed ? typed_res : pred);
  endtask

  // Sender bursts: back-to-back requests, then a random gap
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 0);
    end
  endtask

  // Hold off until every outstanding request has returned its result
  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    ring_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding");
        n_fail++;
      end else begin
        want = pending_q.pop_front();
        if (read_data_o !== want.rdata) begin
          $error("read_data exp %0d got %0d", want.rdata, read_data_o);
          n_fail++;
        end
        if (status_o !== want.status) begin
          $error("status exp %0d got %0d", want.status, status_o);
          n_fail++;
        end
        if (done_count_o !== want.done) begin
          $error("done_count exp %0d got %0d", want.done, done_count_o);
          n_fail++;
        end
        if (used_count_o !== want.used) begin
          $error("used_count exp %0d got %0d", want.used, used_count_o);
          n_fail++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int           pick;
    int unsigned  near;
    logic [CMD_W-1:0]   cmd;
    logic [BYTE_W-1:0]  data;
    logic [FIELD_W-1:0] back_dist;
    logic [FIELD_W-1:0] len;

    n_fail     = 0;
    burst_left = 0;
    big_copies = 0;
    ring_head  = '0;
    ring_used  = '0;
    ring_limit = '0;

    // empty ring corner cases
    row_exp(CMD_READ,      8'h5A, 16'h0000, 16'h0000, 8'h00, RS_NONE,    16'd0, 16'd0);
    row_exp(CMD_BACK_READ, 8'h00, 16'd1,    16'd0,    8'h00, RS_LIMIT,   16'd0, 16'd0);
    row_exp(CMD_COPY,      8'h00, 16'd0,    16'd5,    8'h00, RS_NONE,    16'd0, 16'd0);
    row_exp(CMD_DISCARD,   8'h00, 16'd0,    16'd0,    8'h00, RS_OK,      16'd0, 16'd0);
    row_exp(CMD_DISCARD,   8'h00, 16'd0,    16'd1,    8'h00, RS_DISCARD, 16'd0, 16'd0);
    row_exp(CMD_SPARE_6,   8'hFF, 16'hFFFF, 16'hFFFF, 8'h00, RS_NONE,    16'd0, 16'd0);
    // byte extremes, then reads back inside and beyond the window
    row_exp(CMD_WRITE,     8'h00, 16'd0,    16'd0,    8'h00, RS_OK,      16'd1, 16'd1);
    row_exp(CMD_WRITE,     8'hFF, 16'd0,    16'd0,    8'h00, RS_OK,      16'd1, 16'd2);
    row_exp(CMD_WRITE,     8'hA5, 16'd0,    16'd0,    8'h00, RS_OK,      16'd1, 16'd3);
    row(CMD_BACK_READ, 8'h00, 16'd1, 16'd0);
    row(CMD_BACK_READ, 8'h00, 16'd3, 16'd0);
    row_exp(CMD_BACK_READ, 8'h00, 16'd4,    16'd0,    8'h00, RS_LIMIT,   16'd0, 16'd3);
    row_exp(CMD_BACK_READ, 8'h00, 16'd0,    16'd0,    8'h00, RS_NONE,    16'd0, 16'd3);
    // overlapping copy repeats the pattern
    row(CMD_COPY, 8'h00, 16'd2, 16'd5);
    row_exp(CMD_COPY,      8'h00, 16'd1,    16'd0,    8'h00, RS_NONE,    16'd0, 16'd8);
    row(CMD_READ, 8'h00, 16'd0, 16'd0);
    row(CMD_DISCARD, 8'h00, 16'd0, 16'd2);
    row_exp(CMD_COPY,      8'h00, 16'hFFFF, 16'hFFFF, 8'h00, RS_LIMIT,   16'd0, 16'd5);
    row_exp(CMD_DISCARD,   8'h00, 16'd0,    16'hFFFF, 8'h00, RS_DISCARD, 16'd0, 16'd5);
    row_exp(CMD_SPARE_7,   8'h00, 16'd0,    16'd0,    8'h00, RS_NONE,    16'd0, 16'd5);
    // copy that stops when the ring fills, then the full ring
    row(CMD_COPY, 8'h00, 16'd3, 16'hFFFF);
    row_exp(CMD_WRITE,     8'h11, 16'd0,    16'd0,    8'h00, RS_NONE,    16'd0, 16'h8000);
    row_exp(CMD_COPY,      8'h00, 16'd1,    16'd1,    8'h00, RS_NONE,    16'd0, 16'h8000);
    row(CMD_BACK_READ, 8'h00, 16'h8000, 16'd0);
    row_exp(CMD_BACK_READ, 8'h00, 16'h8001, 16'd0,    8'h00, RS_LIMIT,   16'd0, 16'h8000);
    row(CMD_READ, 8'h00, 16'd0, 16'd0);
    row(CMD_DISCARD, 8'h00, 16'd0, 16'h7FFF);
    row_exp(CMD_CLEAR,     8'h00, 16'd0,    16'd0,    8'h00, RS_OK,      16'd0, 16'd0);

    // reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      issue_request(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].back_dist, dir_rows[i].len,
                    dir_rows[i].typed, dir_rows[i].res);
      pace_sender();
    end

    // random requests; fields a command ignores are pure noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      pick      = $urandom_range(99, 0);
      data      = BYTE_W'($urandom);
      back_dist = FIELD_W'($urandom);
      len       = FIELD_W'($urandom);
      if (pick < 34) begin
        cmd = CMD_WRITE;
      end else if (pick < 46) begin
        cmd = CMD_READ;
      end else if (pick < 56) begin
        cmd  = CMD_DISCARD;
        near = (ring_used < 40) ? ring_used : 40;
        case ($urandom_range(9, 0))
          0:       len = '0;
          1:       ;
          2:       len = ring_used;
          3:       len = ring_used + 1'b1;
          default: len = FIELD_W'($urandom_range(near, 0));
        endcase
      end else if (pick < 76) begin
        cmd       = CMD_COPY;
        back_dist = pick_distance();
        case ($urandom_range(19, 0))
          0:       len = '0;
          1: begin
            // rare long copy; most run into a full ring
            if (big_copies < BIG_COPY_MAX) big_copies++;
            else len = FIELD_W'($urandom_range(40, 1));
          end
          default: len = FIELD_W'($urandom_range(40, 1));
        endcase
      end else if (pick < 92) begin
        cmd       = CMD_BACK_READ;
        back_dist = pick_distance();
      end else if (pick < 94) begin
        cmd = CMD_CLEAR;
      end else if (pick < 97) begin
        cmd = ($urandom_range(1, 0) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      end else begin
        cmd = CMD_WRITE;
      end
      issue_request(cmd, data, back_dist, len, 1'b0, '0);
      pace_sender();
    end

    // wind down
    drain_results();
    repeat (8) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("tb_byte_ring_with_seekback_copy OK");
    end else begin
      $display("tb_byte_ring_with_seekback_copy NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/brsc_pkg.sv
hdl/brsc_ram.sv
hdl/brsc_datapath.sv
hdl/brsc_ctrl.sv
hdl/byte_ring_with_seekback_copy.sv
test/tb_byte_ring_with_seekback_copy.sv
